// ===== rtl/wwdt_pkg.sv =====
package wwdt_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_FEED = 2'd1,
    FUNC_MODE = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RELOAD  = 2'd0,
    CFG_WINDOW  = 2'd1,
    CFG_WARNING = 2'd2,
    CFG_SPARE   = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxBits = 2;

  // Feed sequence bytes
  localparam logic [7:0] FEED_FIRST  = 8'hAA;
  localparam logic [7:0] FEED_SECOND = 8'h55;

  // Mode write bits
  localparam int unsigned MODE_ENABLE    = 0;
  localparam int unsigned MODE_RESET_EN  = 1;
  localparam int unsigned MODE_CLR_WARN  = 2;
  localparam int unsigned MODE_CLR_TMO   = 3;

  // Clamp limits
  localparam int unsigned RELOAD_MIN = 'hFF;
  localparam int unsigned WINDOW_MIN = 'h100;
  localparam int unsigned WARN_MAX   = 'h3FF;

endpackage

// ===== rtl/windowed_watchdog_timer_top.sv =====
// Windowed watchdog. Every input item (tick, feed byte or mode write) gives exactly one
// result item, which appears on the master side in the cycle after acceptance; one item is
// accepted in every cycle, since the counter, flags and feed sequence are all updated by
// a single decrement and a few compares in the cycle an item is taken. The result sits
// in one output register, so the slave side keeps accepting while the master side takes
// results and stalls only while that register is full and not being read. The dog arms
// once the enable bit is set and the 0xAA, 0x55 feed sequence completes; from then on
// ticks count down from the reload value, and reaching zero, or completing a feed above
// the window, is a timeout that sets the sticky timeout flag, pulses reset_pulse when
// reset is enabled and reloads the counter. Configuration writes take effect at once
// and must only be issued while no result is outstanding.
module windowed_watchdog_timer_top #(
  parameter int unsigned COUNTER_BITS = 24,
  parameter int unsigned WARNING_BITS = 10
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // configuration write port
  input  logic                                     cfg_we_i,
  input  logic [wwdt_pkg::CfgIdxBits-1:0]          cfg_addr_i,
  input  logic [COUNTER_BITS-1:0]                  cfg_wdata_i,
  // input items
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [7:0]                               s_axis_tdata,  // [7:0] data
  input  logic [1:0]                               s_axis_tuser,  // [1:0] func
  // result items
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // count_value, enabled, warning_flag, timeout_flag, reset_pulse, window_violation,
  // then zero fill up to the byte boundary
  output logic [((COUNTER_BITS+5+7)/8)*8-1:0]      m_axis_tdata
);
  import wwdt_pkg::*;

  localparam int unsigned OutBits = ((COUNTER_BITS + 5 + 7) / 8) * 8;
  localparam int unsigned WarnMaxInt =
      (WARNING_BITS >= 10) ? WARN_MAX : ((1 << WARNING_BITS) - 1);
  localparam logic [COUNTER_BITS-1:0] ReloadMin = COUNTER_BITS'(RELOAD_MIN);
  localparam logic [COUNTER_BITS-1:0] WindowMin = COUNTER_BITS'(WINDOW_MIN);
  localparam logic [COUNTER_BITS-1:0] CntOnes   = '1;
  localparam logic [WARNING_BITS-1:0] WarnMax   = WARNING_BITS'(WarnMaxInt);

  // configuration registers
  logic [COUNTER_BITS-1:0] reload_q, window_q;
  logic [WARNING_BITS-1:0] warning_q;
  logic [WARNING_BITS-1:0] cfg_warn;

  // watchdog state
  logic [COUNTER_BITS-1:0] counter_q, counter_d;
  logic enable_q, enable_d, reset_en_q, reset_en_d, running_q, running_d;
  logic half_q, half_d, warn_q, warn_d, tmo_q, tmo_d;
  logic pulse_d, viol_d;

  // result register
  logic                    out_valid_q;
  logic [COUNTER_BITS-1:0] out_count_q;
  logic                    out_en_q, out_warn_q, out_tmo_q, out_pulse_q, out_viol_q;

  logic                    in_accept;
  func_e                   func;
  logic [7:0]              data;
  logic [COUNTER_BITS-1:0] cnt_dec;

  assign func          = func_e'(s_axis_tuser);
  assign data          = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // configuration writes, clamped into range
  assign cfg_warn = cfg_wdata_i[WARNING_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q  <= ReloadMin;
      window_q  <= CntOnes;
      warning_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_RELOAD:  reload_q  <= (cfg_wdata_i < ReloadMin) ? ReloadMin : cfg_wdata_i;
        CFG_WINDOW:  window_q  <= (cfg_wdata_i < WindowMin) ? WindowMin : cfg_wdata_i;
        CFG_WARNING: warning_q <= (cfg_warn > WarnMax) ? WarnMax : cfg_warn;
        default: ;
      endcase
    end
  end

  // decrement, held at zero
  assign cnt_dec = (counter_q == '0) ? '0 : counter_q - 1'b1;

  // next state for the accepted item
  always_comb begin
    counter_d  = counter_q;
    enable_d   = enable_q;
    reset_en_d = reset_en_q;
    running_d  = running_q;
    half_d     = half_q;
    warn_d     = warn_q;
    tmo_d      = tmo_q;
    pulse_d    = 1'b0;
    viol_d     = 1'b0;
    case (func)
      FUNC_TICK: begin
        if (enable_q && running_q) begin
          counter_d = cnt_dec;
          if (cnt_dec[COUNTER_BITS-1:WARNING_BITS] == '0 &&
              cnt_dec[WARNING_BITS-1:0] == warning_q) begin
            warn_d = 1'b1;
          end
          if (cnt_dec == '0) begin
            tmo_d     = 1'b1;
            counter_d = reload_q;
            pulse_d   = reset_en_q;
          end
        end
      end
      FUNC_FEED: begin
        if (data == FEED_FIRST) begin
          half_d = 1'b1;
        end else if (data == FEED_SECOND && half_q) begin
          half_d = 1'b0;
          if (enable_q && running_q && counter_q > window_q) begin
            viol_d    = 1'b1;
            tmo_d     = 1'b1;
            counter_d = reload_q;
            pulse_d   = reset_en_q;
          end else begin
            counter_d = reload_q;
            if (enable_q) begin
              running_d = 1'b1;
            end
          end
        end else begin
          half_d = 1'b0;
        end
      end
      FUNC_MODE: begin
        if (data[MODE_ENABLE])   enable_d   = 1'b1;
        if (data[MODE_RESET_EN]) reset_en_d = 1'b1;
        if (data[MODE_CLR_WARN]) warn_d     = 1'b0;
        if (data[MODE_CLR_TMO])  tmo_d      = 1'b0;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q  <= ReloadMin;
      enable_q   <= 1'b0;
      reset_en_q <= 1'b0;
      running_q  <= 1'b0;
      half_q     <= 1'b0;
      warn_q     <= 1'b0;
      tmo_q      <= 1'b0;
    end else if (in_accept) begin
      counter_q  <= counter_d;
      enable_q   <= enable_d;
      reset_en_q <= reset_en_d;
      running_q  <= running_d;
      half_q     <= half_d;
      warn_q     <= warn_d;
      tmo_q      <= tmo_d;
    end
  end

  // result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_count_q <= counter_d;
      out_en_q    <= enable_d;
      out_warn_q  <= warn_d;
      out_tmo_q   <= tmo_d;
      out_pulse_q <= pulse_d;
      out_viol_q  <= viol_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutBits'({out_viol_q, out_pulse_q, out_tmo_q, out_warn_q,
                                   out_en_q, out_count_q});

  // checks
  a_pulse_sets_tmo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_pulse_q |-> out_tmo_q)
    else $error("reset pulse without timeout flag");

  a_viol_sets_tmo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_viol_q |-> out_tmo_q && out_count_q == reload_q)
    else $error("window violation without timeout and reload");

  a_viol_from_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && func != FUNC_FEED |=> !out_viol_q)
    else $error("window violation from an item that is not a feed");

  a_pulse_needs_reset_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_pulse_q |-> reset_en_q)
    else $error("reset pulse while reset is not enabled");

  a_enable_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(enable_q) && !$fell(reset_en_q))
    else $error("sticky enable bit cleared");

endmodule
